// ----- hw/rtl/pff_pkg.sv -----
package pff_pkg;

  localparam int COLUMNS = 128;
  localparam int ROWS = 64;

  localparam int PAGES = (ROWS + 7) / 8;
  localparam int STORE_SIZE = COLUMNS * PAGES;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W = $clog2(STORE_SIZE);
  // room for clamping and end-of-range sums without overflow
  localparam int WORK_W = ((COL_W > ROW_W) ? ((COL_W > 8) ? COL_W : 8)
                                          : ((ROW_W > 8) ? ROW_W : 8)) + 2;

  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam logic [3:0] CLEAR_COUNT = 4'(PAGES);

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] x;
    logic [5:0] y;
    logic [7:0] rect_width;
    logic [6:0] rect_height;
    logic       colour;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] first_page;
    logic [3:0] page_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic rd;
    logic clr_wr;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic fill_last;
    logic clr_last;
  } status_t;

endpackage

// ----- hw/rtl/pff_ctrl.sv -----
module pff_ctrl import pff_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic [1:0] req_type_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_FILL = 6'b000100,
    ST_READ = 6'b001000,
    ST_WIPE = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (req_e'(req_type_i))
            REQ_PIXEL, REQ_FILL: state_d = ST_FILL;
            REQ_CLEAR:           state_d = ST_WIPE;
            REQ_READ:            state_d = ST_READ;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (status_i.empty) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.issue = 1'b1;
          if (status_i.fill_last) state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_DONE;
      end
      ST_WIPE: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        // the last write of a fill lands in this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.result = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.result) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/pff_datapath.sv -----
module pff_datapath import pff_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output out_t    out_o
);

  logic [7:0] mem [STORE_SIZE];

  // request decode at acceptance
  logic [WORK_W-1:0] x_w, y_w, x_c, y_c, w_w, h_w, w_max, h_max, w_c, h_c;
  logic [WORK_W-1:0] last_row, col_end;

  always_comb begin
    x_w = WORK_W'(in_i.x);
    y_w = WORK_W'(in_i.y);
    x_c = (x_w > WORK_W'(COLUMNS - 1)) ? WORK_W'(COLUMNS - 1) : x_w;
    y_c = (y_w > WORK_W'(ROWS - 1)) ? WORK_W'(ROWS - 1) : y_w;
    if (in_i.req_type == REQ_PIXEL) begin
      w_w = WORK_W'(1);
      h_w = WORK_W'(1);
    end else begin
      w_w = WORK_W'(in_i.rect_width);
      h_w = WORK_W'(in_i.rect_height);
    end
    w_max    = WORK_W'(COLUMNS) - x_c;
    h_max    = WORK_W'(ROWS) - y_c;
    w_c      = (w_w > w_max) ? w_max : w_w;
    h_c      = (h_w > h_max) ? h_max : h_w;
    last_row = y_c + h_c - WORK_W'(1);
    col_end  = x_c + w_c - WORK_W'(1);
  end

  req_e              kind_q;
  logic              colour_q, empty_q;
  logic [COL_W-1:0]  col_start_q, col_end_q, col_q;
  logic [PAGE_W-1:0] first_pg_q, last_pg_q, page_q;
  logic [2:0]        lo_q, hi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= req_e'(in_i.req_type);
      colour_q    <= in_i.colour;
      empty_q     <= (w_c == '0) || (h_c == '0);
      col_start_q <= COL_W'(x_c);
      col_end_q   <= COL_W'(col_end);
      first_pg_q  <= PAGE_W'(y_c >> 3);
      last_pg_q   <= PAGE_W'(last_row >> 3);
      lo_q        <= y_c[2:0];
      hi_q        <= last_row[2:0];
    end
  end

  logic col_last, page_last;
  assign col_last  = (col_q == col_end_q);
  assign page_last = (page_q == last_pg_q);

  // column-major walk: columns inside a page, then the next page
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q  <= COL_W'(x_c);
      page_q <= PAGE_W'(y_c >> 3);
    end else if (cmd_i.issue) begin
      if (col_last) begin
        col_q  <= col_start_q;
        page_q <= page_q + PAGE_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  logic [2:0] lo_eff, hi_eff;
  logic [7:0] mask;
  assign lo_eff = (page_q == first_pg_q) ? lo_q : 3'd0;
  assign hi_eff = page_last ? hi_q : 3'd7;
  assign mask   = (FULL_BYTE << lo_eff) & (FULL_BYTE >> (3'd7 - hi_eff));

  logic [ADDR_W-1:0] rd_addr;
  assign rd_addr = ADDR_W'(page_q * COLUMNS) + ADDR_W'(col_q);

  // read-modify-write: read one cycle, write back the next
  logic              rmw_q;
  logic [ADDR_W-1:0] wa_q, clr_q;
  logic [7:0]        wmask_q, rd_data_q, mod_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmw_q <= 1'b0;
      clr_q <= '0;
    end else begin
      rmw_q <= cmd_i.issue;
      if (cmd_i.load) clr_q <= '0;
      else if (cmd_i.clr_wr) clr_q <= clr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      wa_q    <= rd_addr;
      wmask_q <= mask;
    end
  end

  assign mod_data = colour_q ? (rd_data_q | wmask_q) : (rd_data_q & ~wmask_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue || cmd_i.rd) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) mem[clr_q] <= 8'h00;
    else if (rmw_q) mem[wa_q] <= mod_data;
  end

  assign status_o.empty     = empty_q;
  assign status_o.fill_last = col_last && page_last;
  assign status_o.clr_last  = (clr_q == ADDR_W'(STORE_SIZE - 1));

  logic [PAGE_W:0] span;
  out_t            res;
  assign span = {1'b0, last_pg_q} - {1'b0, first_pg_q} + (PAGE_W + 1)'(1);

  always_comb begin
    res = '0;
    unique case (kind_q)
      REQ_PIXEL, REQ_FILL: begin
        if (!empty_q) begin
          res.first_page = 3'(first_pg_q);
          res.page_count = 4'(span);
        end
      end
      REQ_CLEAR: res.page_count = CLEAR_COUNT;
      REQ_READ:  res.read_data  = rd_data_q;
      default:   res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) out_o <= res;
  end

endmodule

// ----- hw/rtl/page_framebuffer_fill_unit.sv -----
// Monochrome page framebuffer: 128 x 64 pixels held as 1024 column bytes, eight
// rows to a byte. Each request (set or clear a pixel, fill a clipped rectangle,
// clear all, read a byte) gives one result word. One request is worked at a time:
// a rectangle takes one read-modify-write of the single store per byte, pipelined,
// and clear all writes zero to every byte. A new request is taken the cycle after
// its result is registered, even while that result waits downstream. After reset
// the block runs the same zeroing pass with in_stall_o high.
module page_framebuffer_fill_unit import pff_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  cmd_t    cmd;
  status_t status;

  pff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pff_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

  // one request in flight: busy right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load == (in_valid_i && !in_stall_o))
    else $error("request load out of step with input handshake");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.issue && cmd.clr_wr))
    else $error("zeroing pass overlaps a fill");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.result |=> out_valid_o)
    else $error("result word not presented");

endmodule

// ----- bench/tb_page_framebuffer_fill_unit.sv -----
module tb_page_framebuffer_fill_unit;
  import pff_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_o;

  page_framebuffer_fill_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  logic [7:0]  fb_model [STORE_SIZE];
  out_t        fb_expect_q [$];
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned kind_count [4];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_flag = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  // last location written, so that reads often land on live data
  int unsigned last_col = 0;
  int unsigned last_row = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    error_count++;
  endtask

  // applies one request to the local copy of the store and gives the result word
  function automatic out_t apply_fb_req(in_t req);
    int unsigned col, row, pg, wid, hgt, end_row, end_pg, base, lo, hi, addr, p, c;
    logic [7:0] mask;
    out_t res;
    col = (req.x > COLUMNS - 1) ? COLUMNS - 1 : req.x;
    row = (req.y > ROWS - 1) ? ROWS - 1 : req.y;
    pg = row / 8;
    res = '0;
    case (req_e'(req.req_type))
      REQ_PIXEL: begin
        mask = 8'd1 << (row % 8);
        addr = pg * COLUMNS + col;
        fb_model[addr] = req.colour ? (fb_model[addr] | mask) : (fb_model[addr] & ~mask);
        res.first_page = 3'(pg);
        res.page_count = 4'd1;
      end
      REQ_FILL: begin
        wid = req.rect_width;
        hgt = req.rect_height;
        if (wid > COLUMNS - col) wid = COLUMNS - col;
        if (hgt > ROWS - row) hgt = ROWS - row;
        if (wid != 0 && hgt != 0) begin
          end_row = row + hgt - 1;
          end_pg = end_row / 8;
          for (p = pg; p <= end_pg; p++) begin
            base = p * 8;
            lo = ((row > base) ? row : base) - base;
            hi = ((end_row < base + 7) ? end_row : base + 7) - base;
            mask = (FULL_BYTE << lo) & (FULL_BYTE >> (7 - hi));
            for (c = 0; c < wid; c++) begin
              addr = p * COLUMNS + col + c;
              fb_model[addr] = req.colour ? (fb_model[addr] | mask)
                                          : (fb_model[addr] & ~mask);
            end
          end
          res.first_page = 3'(pg);
          res.page_count = 4'(end_pg - pg + 1);
        end
      end
      REQ_CLEAR: begin
        for (addr = 0; addr < STORE_SIZE; addr++) fb_model[addr] = 8'h00;
        res.page_count = 4'(PAGES);
      end
      default: begin
        res.read_data = fb_model[pg * COLUMNS + col];
      end
    endcase
    return res;
  endfunction

  function automatic in_t make_req(req_e kind, int unsigned col, int unsigned row,
                                   int unsigned wid, int unsigned hgt, bit colour);
    in_t r;
    r.req_type    = kind;
    r.x           = 7'(col);
    r.y           = 6'(row);
    r.rect_width  = 8'(wid);
    r.rect_height = 7'(hgt);
    r.colour      = colour;
    return r;
  endfunction

  // predicts on every accepted request and checks every accepted result word
  always @(posedge clk_i) begin : result_monitor
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        kind_count[in_i.req_type]++;
        fb_expect_q.push_back(apply_fb_req(in_i));
      end
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (fb_expect_q.size() == 0) begin
          report_mismatch("result word with none expected", out_o, 0);
        end else begin
          want = fb_expect_q.pop_front();
          if (out_o.read_data !== want.read_data)
            report_mismatch("read_data", out_o.read_data, want.read_data);
          if (out_o.first_page !== want.first_page)
            report_mismatch("first_page", out_o.first_page, want.first_page);
          if (out_o.page_count !== want.page_count)
            report_mismatch("page_count", out_o.page_count, want.page_count);
        end
      end
    end
  end

  // receiver side: random stall, or a long hold when asked
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_flag != hold_seen) begin
        hold_seen = hold_flag;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // called and returns just after a falling edge; valid stays high on return
  task automatic send_req(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic test_reset_contents();
    send_req(make_req(REQ_READ, 0, 0, 0, 0, 1'b0));
    send_req(make_req(REQ_READ, 127, 63, 0, 0, 1'b0));
  endtask

  task automatic test_pixels();
    send_req(make_req(REQ_PIXEL, 0, 0, 0, 0, 1'b1));
    send_req(make_req(REQ_PIXEL, 127, 63, 255, 127, 1'b1));
    send_req(make_req(REQ_PIXEL, 5, 13, 0, 0, 1'b1));
    send_req(make_req(REQ_READ, 0, 0, 0, 0, 1'b0));
    send_req(make_req(REQ_READ, 127, 63, 0, 0, 1'b0));
    send_req(make_req(REQ_READ, 5, 8, 0, 0, 1'b0));
    send_req(make_req(REQ_PIXEL, 127, 63, 0, 0, 1'b0));
    send_req(make_req(REQ_READ, 127, 56, 0, 0, 1'b0));
  endtask

  task automatic test_fills();
    send_req(make_req(REQ_FILL, 0, 0, 128, 64, 1'b1));
    send_req(make_req(REQ_READ, 64, 32, 0, 0, 1'b0));
    // oversized rectangle clipped at both edges
    send_req(make_req(REQ_FILL, 100, 40, 255, 127, 1'b0));
    send_req(make_req(REQ_READ, 127, 63, 0, 0, 1'b0));
    send_req(make_req(REQ_READ, 100, 40, 0, 0, 1'b0));
    // empty rectangles
    send_req(make_req(REQ_FILL, 3, 3, 0, 5, 1'b0));
    send_req(make_req(REQ_FILL, 3, 3, 5, 0, 1'b0));
    // short rectangle inside one page
    send_req(make_req(REQ_FILL, 10, 9, 4, 3, 1'b0));
    send_req(make_req(REQ_READ, 10, 8, 0, 0, 1'b0));
    // partial top and bottom pages
    send_req(make_req(REQ_FILL, 20, 5, 3, 12, 1'b0));
    send_req(make_req(REQ_READ, 20, 0, 0, 0, 1'b0));
    send_req(make_req(REQ_READ, 21, 8, 0, 0, 1'b0));
    send_req(make_req(REQ_READ, 22, 16, 0, 0, 1'b0));
  endtask

  task automatic test_clear_all();
    send_req(make_req(REQ_CLEAR, 127, 63, 255, 127, 1'b1));
    send_req(make_req(REQ_READ, 64, 32, 0, 0, 1'b0));
  endtask

  // receiver holds off while requests keep coming, so the input side backs up
  task automatic test_backpressure();
    int unsigned i;
    hold_flag = ~hold_flag;
    for (i = 0; i < 8; i++) begin
      send_req(make_req((i % 2 == 0) ? REQ_PIXEL : REQ_READ, $urandom_range(127),
                        $urandom_range(63), 0, 0, 1'b1));
    end
  endtask

  task automatic test_random(int unsigned n);
    int unsigned i, sel, col, row, wid, hgt;
    req_e kind;
    for (i = 0; i < n; i++) begin
      col = $urandom_range(127);
      row = $urandom_range(63);
      sel = $urandom_range(99);
      if (sel < 85) begin
        wid = $urandom_range(16);
        hgt = $urandom_range(20);
      end else if (sel < 96) begin
        wid = $urandom_range(64);
        hgt = $urandom_range(64);
      end else begin
        wid = $urandom_range(255);
        hgt = $urandom_range(127);
      end
      sel = $urandom_range(199);
      if (sel < 70) kind = REQ_PIXEL;
      else if (sel < 126) kind = REQ_FILL;
      else if (sel < 129) kind = REQ_CLEAR;
      else kind = REQ_READ;
      if (kind == REQ_READ && $urandom_range(1) == 1) begin
        col = last_col + $urandom_range(3);
        row = last_row + $urandom_range(7);
        if (col > 127) col = 127;
        if (row > 63) row = 63;
      end else if (kind == REQ_PIXEL || kind == REQ_FILL) begin
        last_col = col;
        last_row = row;
      end
      send_req(make_req(kind, col, row, wid, hgt, $urandom_range(1)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    // the store comes out of reset all zero
    for (int unsigned a = 0; a < STORE_SIZE; a++) fb_model[a] = 8'h00;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 16;
    recv_idle_pct = 55;
    test_reset_contents();
    test_pixels();
    test_fills();
    test_clear_all();
    test_backpressure();
    test_random(600);

    send_idle_pct = 55;
    recv_idle_pct = 16;
    test_random(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(520);

    in_valid_i <= 1'b0;
    while (fb_expect_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d pixel, %0d fill, %0d clear-all and %0d read requests",
             kind_count[REQ_PIXEL], kind_count[REQ_FILL], kind_count[REQ_CLEAR],
             kind_count[REQ_READ]);
    $display("%0d result words checked, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
